>>> rtl/core/lvsoc_pkg.sv
// Shared constants, breakpoint tables and types for the LiFePO4 charge estimator.
`timescale 1ns / 1ps
`default_nettype none

package lvsoc_pkg;

   // Table geometry and field widths
   localparam int unsigned TABLE_SLOTS = 16;
   localparam int unsigned IDX_W       = 4;
   localparam int unsigned MV_W        = 16;
   localparam int unsigned PCT_W       = 7;
   // Widest segment span is 8000 mV, so offsets and spans fit in 13 bits
   localparam int unsigned DIFF_W      = 13;
   // Largest percentage step between points is 10
   localparam int unsigned STEP_W      = 4;
   // Numerator 2*d*step + span stays below 21 * 8000
   localparam int unsigned NUM_W       = 18;
   localparam int unsigned RECIP_W     = 32;
   localparam int unsigned RECIP_SHIFT = 32;
   localparam int unsigned PRODUCT_W   = NUM_W + RECIP_W;
   // Interpolated increment never exceeds the step
   localparam int unsigned ADD_W       = 4;

   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

   // Breakpoints from the highest voltage down; spare slots repeat the bottom point
   localparam logic [MV_W-1:0] POINT_MV [TABLE_SLOTS] = '{
      16'd54400, 16'd53600, 16'd53120, 16'd52800, 16'd52320, 16'd52160, 16'd52000, 16'd51520,
      16'd51200, 16'd48000, 16'd40000, 16'd40000, 16'd40000, 16'd40000, 16'd40000, 16'd40000
   };

   localparam logic [PCT_W-1:0] POINT_PCT [TABLE_SLOTS] = '{
      7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30,
      7'd20,  7'd10, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0
   };

   // Twice the span of the segment that ends at point seg, kept at least 2
   function automatic logic [RECIP_W-1:0] seg_div(input int unsigned seg);
      logic [MV_W-1:0]    span_mv;
      logic [RECIP_W-1:0] span2;
      span_mv = '0;
      span2   = 32'd2;
      if (seg != 0) begin
         span_mv = POINT_MV[seg-1] - POINT_MV[seg];
         span2   = {15'b0, span_mv, 1'b0};
         if (span2 < 32'd2) begin
            span2 = 32'd2;
         end
      end
      return span2;
   endfunction

   // Reciprocals ceil(2^32 / (2*span)), exact for every numerator below 2^18
   localparam logic [RECIP_W-1:0] SEG_RECIP [TABLE_SLOTS] = '{
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(seg_div(0))  - 64'd1) / 64'(seg_div(0))),
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(seg_div(1))  - 64'd1) / 64'(seg_div(1))),
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(seg_div(2))  - 64'd1) / 64'(seg_div(2))),
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(seg_div(3))  - 64'd1) / 64'(seg_div(3))),
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(seg_div(4))  - 64'd1) / 64'(seg_div(4))),
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(seg_div(5))  - 64'd1) / 64'(seg_div(5))),
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(seg_div(6))  - 64'd1) / 64'(seg_div(6))),
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(seg_div(7))  - 64'd1) / 64'(seg_div(7))),
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(seg_div(8))  - 64'd1) / 64'(seg_div(8))),
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(seg_div(9))  - 64'd1) / 64'(seg_div(9))),
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(seg_div(10)) - 64'd1) / 64'(seg_div(10))),
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(seg_div(11)) - 64'd1) / 64'(seg_div(11))),
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(seg_div(12)) - 64'd1) / 64'(seg_div(12))),
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(seg_div(13)) - 64'd1) / 64'(seg_div(13))),
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(seg_div(14)) - 64'd1) / 64'(seg_div(14))),
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(seg_div(15)) - 64'd1) / 64'(seg_div(15)))
   };

   // Segment lookup result handed to the scaling stage
   typedef struct packed {
      logic [NUM_W-1:0]   num;
      logic [RECIP_W-1:0] recip;
      logic [PCT_W-1:0]   base_pct;
   } interp_type;

endpackage

`default_nettype wire

>>> rtl/core/lvsoc_req_if.sv
// Request channel carrying one pack voltage per beat.
`timescale 1ns / 1ps
`default_nettype none

interface lvsoc_req_if import lvsoc_pkg::*;;
   logic            valid;
   logic            ready;
   logic [MV_W-1:0] pack_millivolts;

   modport source (output valid, output pack_millivolts, input ready);
   modport sink   (input valid, input pack_millivolts, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lvsoc_rsp_if.sv
// Response channel carrying one charge percentage per beat.
`timescale 1ns / 1ps
`default_nettype none

interface lvsoc_rsp_if import lvsoc_pkg::*;;
   logic             valid;
   logic             ready;
   logic [PCT_W-1:0] charge_percent;

   modport source (output valid, output charge_percent, input ready);
   modport sink   (input valid, input charge_percent, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lvsoc_segment.sv
// Breakpoint search and interpolation numerator for one pack voltage.
`timescale 1ns / 1ps
`default_nettype none

module lvsoc_segment import lvsoc_pkg::*; #(
   parameter int unsigned POINTS = 11
) (
   input  logic [MV_W-1:0] pack_mv,
   output interp_type      interp
);

   logic                      top_hit;
   logic                      found;
   logic [IDX_W-1:0]          sel;
   logic [IDX_W-1:0]          sel_hi;
   logic [MV_W-1:0]           span_mv;
   logic [MV_W-1:0]           diff_mv;
   logic [PCT_W-1:0]          step_pct;
   logic [DIFF_W-1:0]         diff;
   logic [DIFF_W-1:0]         span;
   logic [STEP_W-1:0]         step;
   logic [DIFF_W+STEP_W-1:0]  scaled;

   // Pick the highest segment whose low point is at or below the voltage
   always_comb begin
      sel   = '0;
      found = 1'b0;
      for (int i = POINTS - 1; i >= 1; i--) begin
         if (pack_mv >= POINT_MV[i]) begin
            sel   = IDX_W'(i);
            found = 1'b1;
         end
      end
   end

   assign top_hit = (pack_mv >= POINT_MV[0]);
   assign sel_hi  = sel - IDX_W'(1);

   // Offset into the segment, its span and its percentage step
   assign span_mv  = POINT_MV[sel_hi] - POINT_MV[sel];
   assign diff_mv  = pack_mv - POINT_MV[sel];
   assign step_pct = POINT_PCT[sel_hi] - POINT_PCT[sel];
   assign diff     = diff_mv[DIFF_W-1:0];
   assign span     = span_mv[DIFF_W-1:0];
   assign step     = step_pct[STEP_W-1:0];
   assign scaled   = {{STEP_W{1'b0}}, diff} * {{DIFF_W{1'b0}}, step};

   // Numerator 2*d*step + span, divided later by 2*span via its reciprocal
   always_comb begin
      if (top_hit) begin
         interp.num      = '0;
         interp.recip    = '0;
         interp.base_pct = POINT_PCT[0];
      end else if (found) begin
         interp.num      = {scaled, 1'b0} + NUM_W'(span);
         interp.recip    = SEG_RECIP[sel];
         interp.base_pct = POINT_PCT[sel];
      end else begin
         interp.num      = '0;
         interp.recip    = '0;
         interp.base_pct = POINT_PCT[POINTS-1];
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/lifepo4_voltage_to_soc_core.sv
// Top level of the LiFePO4 pack voltage to state-of-charge estimator.
//
// Each request beat carries a resting pack voltage in millivolts; each response
// beat returns the state of charge in whole percent, interpolated in a fixed
// 11-point table (54.40 V = 100 %, down to 40.00 V = 0 %) and rounded half up.
// The pipeline has three register stages, input, middle and output, and a
// taken request beat passes through each in turn; a new beat is taken every
// cycle as long as the response side keeps up. The stage with the 18 x 32
// reciprocal multiply sets the clock rate. Stalls on the response side back
// up through the stages; empty stages still take new beats.
`timescale 1ns / 1ps
`default_nettype none

module lifepo4_voltage_to_soc_core import lvsoc_pkg::*; #(
   parameter int unsigned BREAKPOINTS = 11
) (
   input  logic               clock,
   input  logic               reset,
   lvsoc_req_if.sink          req_bus,
   lvsoc_rsp_if.source        rsp_bus
);

   localparam int unsigned POINTS = (BREAKPOINTS > TABLE_SLOTS) ? TABLE_SLOTS :
                                    ((BREAKPOINTS < 2) ? 2 : BREAKPOINTS);

   logic                 in_vld_ff,  in_vld_in;
   logic [MV_W-1:0]      mv_ff,      mv_in;
   logic                 mid_vld_ff, mid_vld_in;
   interp_type           mid_ff,     mid_in;
   logic                 out_vld_ff, out_vld_in;
   logic [PCT_W-1:0]     pct_ff,     pct_in;

   logic                 out_load;
   logic                 mid_move;
   logic                 in_move;
   interp_type           seg_out;
   logic [PRODUCT_W-1:0] product;
   logic [ADD_W-1:0]     add_pct;
   logic [PCT_W:0]       sum_pct;

   // Stage advance: each stage moves when the one after it is free or moving
   assign out_load = !out_vld_ff || rsp_bus.ready;
   assign mid_move = !mid_vld_ff || out_load;
   assign in_move  = !in_vld_ff || mid_move;

   assign req_bus.ready = in_move;

   // Search the breakpoint table
   lvsoc_segment #(
      .POINTS (POINTS)
   ) u_segment (
      .pack_mv (mv_ff),
      .interp  (seg_out)
   );

   // Scale by the segment reciprocal, add the base percentage, clamp
   assign product = PRODUCT_W'(mid_ff.num) * PRODUCT_W'(mid_ff.recip);
   assign add_pct = product[RECIP_SHIFT +: ADD_W];
   assign sum_pct = {1'b0, mid_ff.base_pct} + (PCT_W + 1)'(add_pct);

   // Next values for the three stages
   always_comb begin
      in_vld_in  = in_move ? req_bus.valid : in_vld_ff;
      mv_in      = (in_move && req_bus.valid) ? req_bus.pack_millivolts : mv_ff;
      mid_vld_in = mid_move ? in_vld_ff : mid_vld_ff;
      mid_in     = (mid_move && in_vld_ff) ? seg_out : mid_ff;
      out_vld_in = out_load ? mid_vld_ff : out_vld_ff;
      pct_in     = pct_ff;
      if (out_load && mid_vld_ff) begin
         if (sum_pct > {1'b0, PCT_FULL}) begin
            pct_in = PCT_FULL;
         end else begin
            pct_in = sum_pct[PCT_W-1:0];
         end
      end
   end

   // Hold valid flags under reset; payload needs none
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         mid_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         mid_vld_ff <= mid_vld_in;
         out_vld_ff <= out_vld_in;
      end
      mv_ff  <= mv_in;
      mid_ff <= mid_in;
      pct_ff <= pct_in;
   end

   assign rsp_bus.valid          = out_vld_ff;
   assign rsp_bus.charge_percent = pct_ff;

   // A taken request beat lands in the input stage
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> in_vld_ff)
      else $error("accepted request beat did not reach the input stage");

   // A full pipeline behind a stalled response takes nothing new
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && mid_vld_ff && out_vld_ff && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("request taken while every stage is full and stalled");

   // A middle beat moving forward becomes a response
   a_mid_to_out: assert property (@(posedge clock) disable iff (reset)
      (mid_vld_ff && out_load) |=> out_vld_ff)
      else $error("middle stage beat lost on its way to the output");

   // A response never reports more than a full pack
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (pct_ff <= PCT_FULL))
      else $error("charge percentage above full scale");

endmodule

`default_nettype wire
